[rtl/fmpa_pkg.sv]
// Shared types, widths and the quarter-wave sine table builder for the FM modulator.
// No dependencies; every other file of the block uses this package.
package fmpa_pkg;

	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_W        = 16;
	localparam int GAIN_W          = 31;
	localparam int PHASE_W         = 32;
	localparam int AMP_W           = 15;
	localparam int IDX_W           = TABLE_ADDR_BITS + 1;
	localparam int TBL_LEN         = (1 << TABLE_ADDR_BITS) + 1;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SAMPLE_W-1:0] iq_t;
	typedef logic [GAIN_W-1:0]          gain_t;
	typedef logic [PHASE_W-1:0]         phase_t;
	typedef logic [AMP_W-1:0]           amp_t;
	typedef logic [IDX_W-1:0]           idx_t;
	typedef amp_t                       sine_rom_t [TBL_LEN];

	// round(32767 * sin(pi/2 * k / 2^N)) from a truncating Q30 Taylor series.
	function automatic amp_t quarter_sine(int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint          sum;
		x    = (PI_Q30 * 64'(k) + (64'd1 << TABLE_ADDR_BITS)) >> (TABLE_ADDR_BITS + 1);
		x2   = (x * x) >> 30;
		term = x;
		sum  = 0;
		for (int n = 0; n < 12; n++) begin
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
			term = ((term * x2) >> 30) / 64'((2 * n + 2) * (2 * n + 3));
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (64'd32767 * $unsigned(sum) + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return amp_t'(v);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int k = 0; k < TBL_LEN; k++) begin
			rom[k] = quarter_sine(k);
		end
		return rom;
	endfunction

endpackage

[rtl/fmpa_sample_if.sv]
// Input channel of the FM modulator: one baseband sample word per handshake.
// Depends on fmpa_pkg for the sample type.
interface fmpa_sample_if;
	logic              valid;
	logic              ready;
	fmpa_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

[rtl/fmpa_iq_if.sv]
// Output channel of the FM modulator: one I/Q word per handshake.
// Depends on fmpa_pkg for the I/Q type.
interface fmpa_iq_if;
	logic          valid;
	logic          ready;
	fmpa_pkg::iq_t i_out;
	fmpa_pkg::iq_t q_out;

	modport source (output valid, output i_out, output q_out, input ready);
	modport sink (input valid, input i_out, input q_out, output ready);
endinterface

[rtl/fm_modulator_phase_accumulate_core.sv]
// FM modulator top level: gain multiply, phase accumulator and quarter-wave sine/cosine ROM.
// Depends on fmpa_pkg, fmpa_sample_if and fmpa_iq_if.
//
// Each accepted sample word is scaled by the phase gain, added to a 32-bit phase
// accumulator that wraps once per turn, and the cosine and sine of the new phase
// leave as one I/Q word. The block accepts one sample every clock while the output
// is not stalled; the result word passes the sample, step, ROM and output registers.
// The phase add is the only feedback loop. The sine table is a 1025-entry ROM with
// two registered read ports, one for sine and one for cosine. Each stage holds its
// word only while the stage after it is full and stalled, so input keeps flowing into
// empty stages while a finished word waits at the output. The gain register resets to zero.
// The user must write it only while no word is in flight; the block does not enforce it.
module fm_modulator_phase_accumulate_core (
	input  logic                clk,
	input  logic                arst_n,
	fmpa_sample_if.sink         sample_ch,
	fmpa_iq_if.source           iq_ch,
	input  logic                gain_we,
	input  fmpa_pkg::gain_t     gain_wdata
);
	import fmpa_pkg::*;

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam phase_t    RND_BIAS = phase_t'(1) << (29 - TABLE_ADDR_BITS);
	localparam idx_t      QUARTER  = idx_t'(1) << TABLE_ADDR_BITS;

	gain_t  gain_q;
	phase_t phase_q;

	logic    valid_s1, valid_s2, valid_s3, valid_s4;
	logic    rdy1, rdy2, rdy3, rdy4;
	sample_t sample_s1;
	phase_t  step_s2;
	amp_t    sin_mag_s3, cos_mag_s3;
	logic    sin_neg_s3, cos_neg_s3;
	iq_t     i_out_s4, q_out_s4;

	logic signed [SAMPLE_W+PHASE_W-1:0] prod;
	phase_t ph_new, ph_rnd;
	logic [1:0] sin_quad, cos_quad;
	logic [TABLE_ADDR_BITS-1:0] k;
	idx_t idx_k, idx_c, sin_addr, cos_addr;
	iq_t  sin_val, cos_val;

	// A stage can take a word when it is empty or its word moves on this cycle.
	assign rdy4 = !valid_s4 || iq_ch.ready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign sample_ch.ready = rdy1;

	// Floor of sample * gain / 2^15, kept modulo 2^32.
	assign prod = $signed(sample_s1) * $signed({1'b0, gain_q});

	assign ph_new   = phase_q + step_s2;
	assign ph_rnd   = ph_new + RND_BIAS;
	assign sin_quad = ph_rnd[PHASE_W-1 -: 2];
	assign cos_quad = sin_quad + 2'd1;
	assign k        = ph_rnd[PHASE_W-3 -: TABLE_ADDR_BITS];
	assign idx_k    = {1'b0, k};
	assign idx_c    = QUARTER - idx_k;
	assign sin_addr = sin_quad[0] ? idx_c : idx_k;
	assign cos_addr = cos_quad[0] ? idx_c : idx_k;

	assign sin_val = sin_neg_s3 ? -iq_t'({1'b0, sin_mag_s3}) : iq_t'({1'b0, sin_mag_s3});
	assign cos_val = cos_neg_s3 ? -iq_t'({1'b0, cos_mag_s3}) : iq_t'({1'b0, cos_mag_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= '0;
			phase_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (gain_we) begin
				gain_q <= gain_wdata;
			end
			if (rdy3 && valid_s2) begin
				phase_q <= ph_new;
			end
			if (rdy1) begin
				valid_s1 <= sample_ch.valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && sample_ch.valid) begin
			sample_s1 <= sample_ch.sample;
		end
		if (rdy2 && valid_s1) begin
			step_s2 <= prod[PHASE_W+14:15];
		end
		if (rdy3 && valid_s2) begin
			sin_mag_s3 <= SINE_ROM[sin_addr];
			cos_mag_s3 <= SINE_ROM[cos_addr];
			sin_neg_s3 <= sin_quad[1];
			cos_neg_s3 <= cos_quad[1];
		end
		if (rdy4 && valid_s3) begin
			i_out_s4 <= cos_val;
			q_out_s4 <= sin_val;
		end
	end

	assign iq_ch.valid = valid_s4;
	assign iq_ch.i_out = i_out_s4;
	assign iq_ch.q_out = q_out_s4;

endmodule

[rtl/fmpa_checker.sv]
// Port-level checks for the FM modulator, attached to the top level by a bind.
// Depends on fmpa_pkg and on the top level's port names.
module fmpa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input fmpa_pkg::iq_t i_out,
	input fmpa_pkg::iq_t q_out
);
	import fmpa_pkg::*;

	// A stalled output word neither disappears nor changes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(i_out) && $stable(q_out))
		else $error("output word dropped or changed while stalled");

	// The table never reaches full negative scale.
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> i_out != iq_t'(16'h8000) && q_out != iq_t'(16'h8000))
		else $error("I or Q at negative full scale");

	// A zero cosine sits on the sine axis, where the sine is at full scale.
	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && i_out == iq_t'(0) |-> q_out == iq_t'(32767) || q_out == iq_t'(-32767))
		else $error("cosine zero without full-scale sine");

	// Nothing leaves the block straight out of reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output word valid as reset ends");

endmodule

bind fm_modulator_phase_accumulate_core fmpa_checker u_fmpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (iq_ch.valid),
	.out_ready (iq_ch.ready),
	.i_out     (iq_ch.i_out),
	.q_out     (iq_ch.q_out)
);
